// File: src/qte_pkg.sv
// Shared widths, defaults and the CORDIC angle table for the quaternion to Euler unit.
package qte_pkg;

    localparam int CW       = 36;  // CORDIC vector width, signed
    localparam int AW       = 30;  // angle accumulator width, units of 2^-20 degree
    localparam int ACC_FRAC = 20;
    localparam int SQW      = 62;  // square root remainder and root width
    localparam int SQ_BITS  = 31;  // result bits of the square root
    localparam int TAB_LEN  = 24;

    localparam int DEF_CORDIC_STAGES   = 16;
    localparam int DEF_ANGLE_FRAC_BITS = 7;

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest
    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:       v = 30'sd47185920;
            1:       v = 30'sd27855475;
            2:       v = 30'sd14718068;
            3:       v = 30'sd7471121;
            4:       v = 30'sd3750058;
            5:       v = 30'sd1876857;
            6:       v = 30'sd938658;
            7:       v = 30'sd469357;
            8:       v = 30'sd234682;
            9:       v = 30'sd117342;
            10:      v = 30'sd58671;
            11:      v = 30'sd29335;
            12:      v = 30'sd14668;
            13:      v = 30'sd7334;
            14:      v = 30'sd3667;
            15:      v = 30'sd1833;
            16:      v = 30'sd917;
            17:      v = 30'sd458;
            18:      v = 30'sd229;
            19:      v = 30'sd115;
            20:      v = 30'sd57;
            21:      v = 30'sd29;
            22:      v = 30'sd14;
            23:      v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/qte_sqrt_cell.sv
// One digit of the pipelined integer square root, with a payload carried alongside.
module qte_sqrt_cell import qte_pkg::*; #(
    parameter int K  = 0,
    parameter int PW = 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [SQW-1:0] i_v,
    input  logic [SQW-1:0] i_r,
    input  logic [PW-1:0]  i_pass,
    output logic [SQW-1:0] o_v,
    output logic [SQW-1:0] o_r,
    output logic [PW-1:0]  o_pass
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    logic [SQW-1:0] trial;
    logic [SQW-1:0] n_v, n_r;
    logic [SQW-1:0] r_v, r_r;
    logic [PW-1:0]  r_pass;

    always_comb begin
        trial = i_r + BIT;
        if (i_v >= trial) begin
            n_v = i_v - trial;
            n_r = (i_r >> 1) + BIT;
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_r    <= n_r;
            r_pass <= i_pass;
        end
    end

    assign o_v    = r_v;
    assign o_r    = r_r;
    assign o_pass = r_pass;

endmodule

// File: src/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation stage.
module qte_cordic_cell import qte_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [AW-1:0] i_acc,
    input  logic                 i_zero,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [AW-1:0] o_acc,
    output logic                 o_zero
);

    localparam logic signed [AW-1:0] ANG = atan_entry(STAGE);

    logic signed [CW-1:0] dx, dy, n_x, n_y, r_x, r_y;
    logic signed [AW-1:0] n_acc, r_acc;
    logic                 r_zero;

    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (!i_y[CW-1]) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_acc = i_acc + ANG;
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_acc = i_acc - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_zero = r_zero;

endmodule

// File: src/quaternion_to_euler_zyx_unit.sv
// Top level: quaternion to ZYX Euler angles, fully pipelined square root and CORDIC chains.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------------
//  input    | i_valid / o_ready | i_quat_w, i_quat_x, i_quat_y, i_quat_z
//  output   | o_valid / i_ready | o_roll_angle, o_pitch_angle, o_yaw_angle,
//           |                   | o_pitch_clamped
//
// One item enters per clock unless a full output register stalls; the path runs through the
// 31-cell square root chain and the CORDIC chain that follows it.
// Reset clears only the valid line; the datapath registers are not reset.
// A full output register that is not taken holds the whole chain in place.
module quaternion_to_euler_zyx_unit import qte_pkg::*; #(
    parameter int CORDIC_STAGES   = DEF_CORDIC_STAGES,
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic               o_pitch_clamped
);

    localparam int NV  = 36 + CORDIC_STAGES;
    localparam int PW  = 5 * CW + 1;
    localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int LRY = ((180 << ANGLE_FRAC_BITS) > 32767) ? 32767 : (180 << ANGLE_FRAC_BITS);
    localparam int LP  = ((90 << ANGLE_FRAC_BITS) > 16383) ? 16383 : (90 << ANGLE_FRAC_BITS);
    localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< 30);
    localparam logic signed [AW-1:0] A90 = AW'(64'sd90 <<< ACC_FRAC);

    // round half up, then clamp to the angle and field limit
    function automatic logic signed [15:0] to_field(input logic signed [AW-1:0] acc,
                                                    input int lim);
        logic signed [31:0] v;
        logic signed [31:0] l;
        l = 32'(lim);
        v = (32'(acc) + (32'sd1 <<< (SH - 1))) >>> SH;
        if (v > l)  v = l;
        if (v < -l) v = -l;
        return v[15:0];
    endfunction

    logic          en;
    logic [NV-1:0] r_vld;

    assign en      = !r_vld[NV-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // products
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
        end
    end

    // product sums; saturate the pitch sine term
    logic signed [CW-1:0] n_sr, n_cr, n_sy, n_cy, n_spr, n_sp;
    logic                 n_clp;
    logic signed [CW-1:0] r_sr, r_cr, r_sy, r_cy, r_sp;
    logic                 r_clp;
    logic [SQ_BITS-1:0]   r_sq;

    always_comb begin
        n_sr  = (CW'(r_wx) + CW'(r_yz)) <<< 1;
        n_cr  = ONE - ((CW'(r_xx) + CW'(r_yy)) <<< 1);
        n_sy  = (CW'(r_wz) + CW'(r_xy)) <<< 1;
        n_cy  = ONE - ((CW'(r_yy) + CW'(r_zz)) <<< 1);
        n_spr = (CW'(r_wy) - CW'(r_zx)) <<< 1;
        n_clp = 1'b0;
        n_sp  = n_spr;
        if (n_spr > ONE) begin
            n_sp  = ONE;
            n_clp = 1'b1;
        end else if (n_spr < -ONE) begin
            n_sp  = -ONE;
            n_clp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr  <= n_sr;
            r_cr  <= n_cr;
            r_sy  <= n_sy;
            r_cy  <= n_cy;
            r_sp  <= n_sp;
            r_clp <= n_clp;
            r_sq  <= n_sp[CW-1] ? SQ_BITS'(-n_sp) : SQ_BITS'(n_sp);
        end
    end

    // radicand 2^60 - s*s; the square is taken at full width
    logic [SQW-1:0] sq_prod;
    logic [SQW-1:0] r_v0;
    logic [PW-1:0]  r_p3;

    assign sq_prod = r_sq * r_sq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v0 <= (SQW'(1) << 60) - sq_prod;
            r_p3 <= {r_sr, r_cr, r_sy, r_cy, r_sp, r_clp};
        end
    end

    // square root chain, most significant digit first
    logic [SQW-1:0] s_v [SQ_BITS+1];
    logic [SQW-1:0] s_r [SQ_BITS+1];
    logic [PW-1:0]  s_p [SQ_BITS+1];

    assign s_v[0] = r_v0;
    assign s_r[0] = '0;
    assign s_p[0] = r_p3;

    for (genvar g = 0; g < SQ_BITS; g++) begin : g_sqrt
        qte_sqrt_cell #(.K(SQ_BITS - 1 - g), .PW(PW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_v    (s_v[g]),
            .i_r    (s_r[g]),
            .i_pass (s_p[g]),
            .o_v    (s_v[g+1]),
            .o_r    (s_r[g+1]),
            .o_pass (s_p[g+1])
        );
    end

    // unpack and pre-rotate into the right half plane
    logic signed [CW-1:0] in_y [3];
    logic signed [CW-1:0] in_x [3];
    logic                 q_clp;

    assign in_y[0] = s_p[SQ_BITS][PW-1 -: CW];
    assign in_x[0] = s_p[SQ_BITS][PW-1-CW -: CW];
    assign in_y[2] = s_p[SQ_BITS][PW-1-2*CW -: CW];
    assign in_x[2] = s_p[SQ_BITS][PW-1-3*CW -: CW];
    assign in_y[1] = s_p[SQ_BITS][PW-1-4*CW -: CW];
    assign in_x[1] = CW'({1'b0, s_r[SQ_BITS][SQ_BITS-1:0]});
    assign q_clp   = s_p[SQ_BITS][0];

    logic signed [CW-1:0] c_x   [3][CORDIC_STAGES+1];
    logic signed [CW-1:0] c_y   [3][CORDIC_STAGES+1];
    logic signed [AW-1:0] c_acc [3][CORDIC_STAGES+1];
    logic                 c_z   [3][CORDIC_STAGES+1];

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic signed [CW-1:0] n_x, n_y, r_x, r_y;
        logic signed [AW-1:0] n_acc, r_acc;
        logic                 r_z;

        always_comb begin
            n_x   = in_x[l];
            n_y   = in_y[l];
            n_acc = '0;
            if (in_x[l][CW-1]) begin
                if (!in_y[l][CW-1]) begin
                    n_x   = in_y[l];
                    n_y   = -in_x[l];
                    n_acc = A90;
                end else begin
                    n_x   = -in_y[l];
                    n_y   = in_x[l];
                    n_acc = -A90;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_acc <= n_acc;
                r_z   <= (in_x[l] == '0) && (in_y[l] == '0);
            end
        end

        assign c_x[l][0]   = r_x;
        assign c_y[l][0]   = r_y;
        assign c_acc[l][0] = r_acc;
        assign c_z[l][0]   = r_z;

        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            qte_cordic_cell #(.STAGE(s)) u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_x    (c_x[l][s]),
                .i_y    (c_y[l][s]),
                .i_acc  (c_acc[l][s]),
                .i_zero (c_z[l][s]),
                .o_x    (c_x[l][s+1]),
                .o_y    (c_y[l][s+1]),
                .o_acc  (c_acc[l][s+1]),
                .o_zero (c_z[l][s+1])
            );
        end
    end

    // carry the clamp flag beside the CORDIC chain
    logic [CORDIC_STAGES:0] r_clp_line;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clp_line <= {r_clp_line[CORDIC_STAGES-1:0], q_clp};
        end
    end

    // output register
    logic signed [15:0] r_roll, r_yaw;
    logic signed [15:0] n_pitch;
    logic signed [14:0] r_pitch;
    logic               r_out_clp;

    assign n_pitch = c_z[1][CORDIC_STAGES] ? 16'sd0 : to_field(c_acc[1][CORDIC_STAGES], LP);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll    <= c_z[0][CORDIC_STAGES] ? 16'sd0 : to_field(c_acc[0][CORDIC_STAGES], LRY);
            r_yaw     <= c_z[2][CORDIC_STAGES] ? 16'sd0 : to_field(c_acc[2][CORDIC_STAGES], LRY);
            r_pitch   <= n_pitch[14:0];
            r_out_clp <= r_clp_line[CORDIC_STAGES];
        end
    end

    assign o_roll_angle    = r_roll;
    assign o_pitch_angle   = r_pitch;
    assign o_yaw_angle     = r_yaw;
    assign o_pitch_clamped = r_out_clp;

endmodule

// File: tb/tb_top.sv
// Testbench for the quaternion to ZYX Euler unit: queued stimulus, self-checking predictor.
module tb_top;
    import qte_pkg::*;

    localparam int STAGES    = DEF_CORDIC_STAGES;
    localparam int FRAC_BITS = DEF_ANGLE_FRAC_BITS;
    localparam int LATENCY   = 36 + STAGES;
    localparam int N_RANDOM  = 930;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_roll_angle;
    logic signed [14:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;
    logic               o_pitch_clamped;

    t_quat  pending_quats[$];
    t_euler expected_angles[$];
    int     error_count;
    bit     long_hold;

    quaternion_to_euler_zyx_unit #(
        .CORDIC_STAGES  (STAGES),
        .ANGLE_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_quat_w       (i_quat_w),
        .i_quat_x       (i_quat_x),
        .i_quat_y       (i_quat_y),
        .i_quat_z       (i_quat_z),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_roll_angle   (o_roll_angle),
        .o_pitch_angle  (o_pitch_angle),
        .o_yaw_angle    (o_yaw_angle),
        .o_pitch_clamped(o_pitch_clamped)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ---------------------------------------------------------------
    // Predictor: exact integer arithmetic at the block's scales
    // ---------------------------------------------------------------

    // floor square root of a 64-bit value, bit by bit
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring CORDIC atan2(sy, cx) in units of 2^-20 degree
    function automatic longint vector_angle(input longint sy, input longint cx);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (cx == 0 && sy == 0)
            return 0;
        // pre-rotate the left half plane by a quarter turn
        if (cx < 0) begin
            if (sy >= 0) begin
                t = cx; cx = sy; sy = -t;
                acc = 64'sd90 <<< ACC_FRAC;
            end else begin
                t = cx; cx = -sy; sy = t;
                acc = -(64'sd90 <<< ACC_FRAC);
            end
        end
        for (int i = 0; i < STAGES && i < TAB_LEN; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (sy >= 0) begin
                cx  = cx + dx;
                sy  = sy - dy;
                acc = acc + longint'(atan_entry(i));
            end else begin
                cx  = cx - dx;
                sy  = sy + dy;
                acc = acc - longint'(atan_entry(i));
            end
        end
        return acc;
    endfunction

    // round half up to the output unit, then clamp to degrees and to the field
    function automatic longint angle_to_field(input longint acc, input longint deg_lim,
                                              input int width);
        int     sh;
        longint v;
        longint lim;
        longint flim;
        sh   = ACC_FRAC - FRAC_BITS;
        v    = (acc + (64'sd1 <<< (sh - 1))) >>> sh;
        lim  = deg_lim <<< FRAC_BITS;
        flim = (64'sd1 <<< (width - 1)) - 1;
        if (lim > flim)
            lim = flim;
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    function automatic t_euler predict_euler(input t_quat q);
        longint one;
        longint w, x, y, z;
        longint s_roll, c_roll, s_yaw, c_yaw, s_pitch, c_pitch;
        longint unsigned mag;
        t_euler e;
        one = 64'sd1 <<< 30;
        w = q.w; x = q.x; y = q.y; z = q.z;
        s_roll  = 2 * (w * x + y * z);
        c_roll  = one - 2 * (x * x + y * y);
        s_yaw   = 2 * (w * z + x * y);
        c_yaw   = one - 2 * (y * y + z * z);
        s_pitch = 2 * (w * y - z * x);
        e.clamped = 1'b0;
        // saturate the pitch sine to unit magnitude
        if (s_pitch > one) begin
            s_pitch = one;
            e.clamped = 1'b1;
        end else if (s_pitch < -one) begin
            s_pitch = -one;
            e.clamped = 1'b1;
        end
        mag     = (s_pitch < 0) ? -s_pitch : s_pitch;
        c_pitch = isqrt((64'd1 << 60) - mag * mag);
        e.roll  = 16'(angle_to_field(vector_angle(s_roll, c_roll), 180, 16));
        e.pitch = 15'(angle_to_field(vector_angle(s_pitch, c_pitch), 90, 15));
        e.yaw   = 16'(angle_to_field(vector_angle(s_yaw, c_yaw), 180, 16));
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic t_quat mk_quat(input int w, input int x, input int y, input int z);
        t_quat q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    // append an item to the pending queue
    function automatic void queue_quat(input t_quat q);
        pending_quats = {pending_quats, q};
    endfunction

    // roughly unit quaternion: pick three components, derive the fourth
    function automatic t_quat random_unit_quat();
        int a, b, c, d;
        longint r;
        a = $urandom_range(0, 23170) - 11585;
        b = $urandom_range(0, 23170) - 11585;
        c = $urandom_range(0, 23170) - 11585;
        r = 64'sd1073741824 - a * a - b * b - c * c;
        d = (r > 0) ? int'(isqrt(r)) : 0;
        if (d > 32767)
            d = 32767;
        if ($urandom_range(0, 1))
            d = -d;
        // jitter so rounding near unit length is exercised
        d = d + $urandom_range(0, 8) - 4;
        case ($urandom_range(0, 3))
            0: return mk_quat(d, a, b, c);
            1: return mk_quat(a, d, b, c);
            2: return mk_quat(a, b, d, c);
            default: return mk_quat(a, b, c, d);
        endcase
    endfunction

    initial begin
        t_quat q;
        // extremes and zero
        queue_quat(mk_quat(0, 0, 0, 0));
        queue_quat(mk_quat(32767, 0, 0, 0));
        queue_quat(mk_quat(-32768, 0, 0, 0));
        queue_quat(mk_quat(-32768, -32768, -32768, -32768));
        queue_quat(mk_quat(32767, 32767, 32767, 32767));
        queue_quat(mk_quat(-1, -1, -1, -1));
        queue_quat(mk_quat(32767, -32768, 32767, -32768));
        // pitch sine near and beyond unit magnitude, both signs
        queue_quat(mk_quat(32767, 0, 32767, 0));
        queue_quat(mk_quat(32767, 0, -32768, 0));
        queue_quat(mk_quat(23170, 0, 23170, 0));
        queue_quat(mk_quat(23170, 0, 23171, 0));
        // pure x, y, z half turns: negative cosine, zero sine gives +180
        queue_quat(mk_quat(0, 32767, 0, 0));
        queue_quat(mk_quat(0, 0, 0, 32767));
        queue_quat(mk_quat(0, 0, 32767, 0));
        // quarter turns about the x and z axes, both senses
        queue_quat(mk_quat(23170, 23170, 0, 0));
        queue_quat(mk_quat(23170, -23170, 0, 0));
        queue_quat(mk_quat(23170, 0, 0, 23170));
        queue_quat(mk_quat(23170, 0, 0, -23170));
        // negative cosine with negative sine
        queue_quat(mk_quat(-16384, 28378, 0, 0));
        queue_quat(mk_quat(16384, -28378, 0, -1000));
        // non-unit quaternion
        queue_quat(mk_quat(100, -200, 300, -400));
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) < 7)
                q = random_unit_quat();
            else
                q = mk_quat($urandom, $urandom, $urandom, $urandom);
            queue_quat(q);
        end
    end

    // ---------------------------------------------------------------
    // Driver: bursts with gaps, changes at the falling edge
    // ---------------------------------------------------------------
    int   burst_left;
    int   gap_left;
    logic o_ready_seen;

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(negedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_quat_w   <= '0;
            i_quat_x   <= '0;
            i_quat_y   <= '0;
            i_quat_z   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            next_valid = i_valid;
            // retire the item taken at the last rising edge
            if (i_valid && o_ready_seen) begin
                expected_angles = {expected_angles, predict_euler(pending_quats.pop_front())};
                next_valid = 1'b0;
            end
            // offer a new item only when none is waiting
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_quats.size() > 0) begin
                    next_valid = 1'b1;
                    i_quat_w <= pending_quats[0].w;
                    i_quat_x <= pending_quats[0].x;
                    i_quat_y <= pending_quats[0].y;
                    i_quat_z <= pending_quats[0].z;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // capture the input handshake at the rising edge for the driver
    always @(posedge i_clk)
        o_ready_seen <= i_valid && o_ready;

    // ---------------------------------------------------------------
    // Receiver stall pattern, with one long hold-off early in the run
    // ---------------------------------------------------------------
    int out_count;
    int hold_cycles;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            long_hold   <= 1'b0;
            i_ready     <= 1'b0;
        end else if (out_count == 30 && hold_cycles == 0 && !long_hold) begin
            long_hold   <= 1'b1;
            hold_cycles <= 3 * LATENCY;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 1) begin
            hold_cycles <= hold_cycles - 1;
            i_ready     <= 1'b0;
        end else begin
            hold_cycles <= 0;
            // stretches of full throughput alternate with random stalls
            if (out_count % 200 < 60)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each taken result with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_euler want;
        if (!i_rst_n) begin
            out_count <= 0;
        end else if (o_valid && i_ready) begin
            out_count <= out_count + 1;
            if (expected_angles.size() == 0) begin
                $display("%0t: result with nothing expected: roll %0d pitch %0d yaw %0d",
                         $time, o_roll_angle, o_pitch_angle, o_yaw_angle);
                error_count++;
            end else begin
                want = expected_angles.pop_front();
                if (o_roll_angle !== want.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                             o_roll_angle);
                    error_count++;
                end
                if (o_pitch_angle !== want.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                             o_pitch_angle);
                    error_count++;
                end
                if (o_yaw_angle !== want.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, want.yaw,
                             o_yaw_angle);
                    error_count++;
                end
                if (o_pitch_clamped !== want.clamped) begin
                    $display("%0t: pitch_clamped expected %0b actual %0b", $time,
                             want.clamped, o_pitch_clamped);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        wait (pending_quats.size() == 0 && !i_valid);
        wait (expected_angles.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (error_count == 0)
            $display("quaternion_to_euler_zyx_unit regression: pass");
        else
            $display("quaternion_to_euler_zyx_unit regression: fail");
        $finish;
    end

    initial begin
        #200000;
        $display("quaternion_to_euler_zyx_unit regression: fail");
        $finish;
    end

endmodule
